@@ rtl/fti_pkg.sv @@
package fti_pkg;

    // Field and state widths.
    localparam int CPU_W   = 13;
    localparam int SUM_W   = 23;
    localparam int IDX_W   = 6;
    localparam int DRIFT_W = 21;
    localparam int TIME_W  = 42;
    localparam int SUBNS_W = 10;

    // Shared divider: dividend and divisor widths.
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 45;

    // Shared multiplier: operand and product widths.
    localparam int MUL_AW = 32;
    localparam int MUL_BW = 20;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [CPU_W-1:0]  CPU_RESET = 13'd200;
    localparam logic [MUL_BW-1:0] PPM_SCALE = 20'd1000000;
    localparam logic [MUL_BW-1:0] NS_PER_US = 20'd1000;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

endpackage

@@ rtl/fti_div.sv @@
module fti_div
    import fti_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   trial_diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    assign trial      = {rem_reg, quo_reg[DIV_NW-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign fits       = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/fti_mul.sv @@
module fti_mul
    import fti_pkg::*;
(
    input  logic              aclk,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic [MUL_PW-1:0] product
);

    logic [MUL_PW-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= MUL_PW'(a) * MUL_PW'(b);
    end

    assign product = product_reg;

endmodule

@@ rtl/fine_timestamp_interpolator_top.sv @@
// Fine timestamp interpolator. A calibration sample word (action 0) folds the
// phase of its cycle count into a running sum; every CAL_SAMPLES samples the
// mean phase is stored, the block becomes calibrated and, if the micro count
// rose over the round, the drift in ppm is re-estimated. A query word (action 1)
// returns micro_count*1000 ns, plus the interpolated sub-microsecond part once
// calibrated. One word is worked on at a time and s_ready is low until its
// result sits in the output register. All divisions go through one shared
// bit-serial divider of 34 steps and all products through one registered
// multiplier.
module fine_timestamp_interpolator_top
    import fti_pkg::*;
#(
    parameter int CAL_SAMPLES = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [31:0]               s_cycles_first,
    input  logic [31:0]               s_micro_count,
    input  logic [31:0]               s_cycles_second,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [TIME_W-1:0]         m_time_ns,
    output logic                      m_fine_used,
    output logic                      m_calibration_done,
    output logic [CPU_W-1:0]          m_mean_phase_out,
    output logic signed [DRIFT_W-1:0] m_drift_out
);

    localparam logic REG_CPU_IDX = 1'b0;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_SMP_GO    = 14'h0002,
        ST_SMP_ACC   = 14'h0004,
        ST_SMP_MEAN  = 14'h0008,
        ST_SMP_MUL1  = 14'h0010,
        ST_SMP_MUL2  = 14'h0020,
        ST_SMP_DRIFT = 14'h0040,
        ST_QRY_GO    = 14'h0080,
        ST_QRY_SCALE = 14'h0100,
        ST_QRY_SNS   = 14'h0200,
        ST_QRY_BASE  = 14'h0400,
        ST_QRY_SUM   = 14'h0800,
        ST_DIV_WAIT  = 14'h1000,
        ST_FIN       = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg;

    logic [CPU_W-1:0]   cpu_cfg_reg;

    logic [31:0]        c1_reg;
    logic [31:0]        us_reg;
    logic [31:0]        c2_reg;
    logic [CPU_W-1:0]   cpu_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CPU_W-1:0]   first_phase_reg;
    logic [31:0]        first_micro_reg;
    logic [CPU_W-1:0]   mean_reg;
    logic [DRIFT_W-1:0] drift_reg;
    logic               cal_reg;

    logic [CPU_W-1:0]   phase_reg;
    logic [DIV_DW-1:0]  ideal_reg;
    logic               neg_reg;
    logic [SUBNS_W-1:0] subns_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               fine_reg;
    logic               done_reg;

    logic               m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]  m_time_reg;
    logic               m_fine_reg;
    logic               m_done_reg;
    logic [CPU_W-1:0]   m_mean_reg;
    logic [DRIFT_W-1:0] m_drift_reg;

    logic               div_start;
    logic [DIV_NW-1:0]  div_n;
    logic [DIV_DW-1:0]  div_d;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;
    logic [DIV_DW-1:0]  div_rem;

    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic [MUL_PW-1:0]  mul_p;

    logic               cfg_wr;
    logic               in_acc;
    logic               out_load;
    logic [CPU_W-1:0]   cpu_eff;
    logic [CPU_W-1:0]   phase;
    logic [SUM_W-1:0]   sum_new;
    logic               round_last;
    logic [CPU_W:0]     phase_diff;
    logic [CPU_W:0]     phase_mag;
    logic [31:0]        mid;
    logic [31:0]        sub_arg;
    logic [DIV_NW-1:0]  drift_signed;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CPU_IDX) ? {{(32 - CPU_W){1'b0}}, cpu_cfg_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_cfg_reg <= CPU_RESET;
        end else if (cfg_wr && paddr[2] == REG_CPU_IDX) begin
            cpu_cfg_reg <= pwdata[CPU_W-1:0];
        end
    end

    assign cpu_eff = (cpu_cfg_reg == '0) ? CPU_W'(1) : cpu_cfg_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // Datapath helpers.
    assign phase      = div_rem[CPU_W-1:0];
    assign sum_new    = (idx_reg == '0) ? SUM_W'(phase) : sum_reg + SUM_W'(phase);
    assign round_last = ({1'b0, idx_reg} + (IDX_W + 1)'(1)) >= (IDX_W + 1)'(CAL_SAMPLES);
    assign phase_diff = {1'b0, phase_reg} - {1'b0, first_phase_reg};
    assign phase_mag  = phase_diff[CPU_W] ? (~phase_diff + (CPU_W + 1)'(1)) : phase_diff;
    assign mid        = c1_reg + ((c2_reg - c1_reg) >> 1);
    assign sub_arg    = mid - 32'(mean_reg) + 32'(cpu_reg);
    assign drift_signed = neg_reg ? (~div_quo + DIV_NW'(1)) : div_quo;

    fti_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    fti_mul u_mul (
        .aclk    (aclk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // Operand selection for the shared units and the next state.
    always_comb begin
        div_start  = 1'b0;
        div_n      = '0;
        div_d      = '0;
        mul_a      = '0;
        mul_b      = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_action == ACT_SAMPLE) ? ST_SMP_GO : ST_QRY_GO;
                end
            end
            ST_SMP_GO: begin
                div_start  = 1'b1;
                div_n      = DIV_NW'(c1_reg);
                div_d      = DIV_DW'(cpu_reg);
                state_next = ST_DIV_WAIT;
            end
            ST_SMP_ACC: begin
                if (round_last) begin
                    div_start  = 1'b1;
                    div_n      = DIV_NW'(sum_new);
                    div_d      = DIV_DW'(CAL_SAMPLES);
                    state_next = ST_DIV_WAIT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SMP_MEAN: begin
                mul_a      = us_reg - first_micro_reg;
                mul_b      = MUL_BW'(cpu_reg);
                state_next = (us_reg > first_micro_reg) ? ST_SMP_MUL1 : ST_FIN;
            end
            ST_SMP_MUL1: begin
                mul_a      = MUL_AW'(phase_mag);
                mul_b      = PPM_SCALE;
                state_next = ST_SMP_MUL2;
            end
            ST_SMP_MUL2: begin
                div_start  = 1'b1;
                div_n      = mul_p[DIV_NW-1:0];
                div_d      = ideal_reg;
                state_next = ST_DIV_WAIT;
            end
            ST_SMP_DRIFT: begin
                state_next = ST_FIN;
            end
            ST_QRY_GO: begin
                if (cal_reg) begin
                    div_start  = 1'b1;
                    div_n      = DIV_NW'(sub_arg);
                    div_d      = DIV_DW'(cpu_reg);
                    state_next = ST_DIV_WAIT;
                end else begin
                    state_next = ST_QRY_BASE;
                end
            end
            ST_QRY_SCALE: begin
                mul_a      = MUL_AW'(div_rem[CPU_W-1:0]);
                mul_b      = NS_PER_US;
                state_next = ST_QRY_SNS;
            end
            ST_QRY_SNS: begin
                div_start  = 1'b1;
                div_n      = DIV_NW'(mul_p[SUM_W-1:0]);
                div_d      = DIV_DW'(cpu_reg);
                state_next = ST_DIV_WAIT;
            end
            ST_QRY_BASE: begin
                mul_a      = us_reg;
                mul_b      = NS_PER_US;
                state_next = ST_QRY_SUM;
            end
            ST_QRY_SUM: begin
                state_next = ST_FIN;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ret_reg;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and calibration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ret_reg         <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            idx_reg         <= '0;
            sum_reg         <= '0;
            first_phase_reg <= '0;
            first_micro_reg <= '0;
            mean_reg        <= '0;
            drift_reg       <= '0;
            cal_reg         <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_SMP_GO: begin
                    ret_reg <= ST_SMP_ACC;
                end
                ST_SMP_ACC: begin
                    sum_reg <= sum_new;
                    if (idx_reg == '0) begin
                        first_phase_reg <= phase;
                        first_micro_reg <= us_reg;
                    end
                    if (round_last) begin
                        ret_reg <= ST_SMP_MEAN;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_SMP_MEAN: begin
                    mean_reg <= div_quo[CPU_W-1:0];
                    cal_reg  <= 1'b1;
                    idx_reg  <= '0;
                end
                ST_SMP_MUL2: begin
                    ret_reg <= ST_SMP_DRIFT;
                end
                ST_SMP_DRIFT: begin
                    drift_reg <= drift_signed[DRIFT_W-1:0];
                end
                ST_QRY_GO: begin
                    ret_reg <= ST_QRY_SCALE;
                end
                ST_QRY_SNS: begin
                    ret_reg <= ST_QRY_BASE;
                end
                default: begin
                end
            endcase
        end
    end

    // Item payload and result registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            c1_reg    <= s_cycles_first;
            us_reg    <= s_micro_count;
            c2_reg    <= s_cycles_second;
            cpu_reg   <= cpu_eff;
            time_reg  <= '0;
            fine_reg  <= (s_action == ACT_QUERY) && cal_reg;
            done_reg  <= 1'b0;
            subns_reg <= '0;
        end
        case (state_reg)
            ST_SMP_ACC: begin
                phase_reg <= phase;
            end
            ST_SMP_MEAN: begin
                done_reg <= 1'b1;
            end
            ST_SMP_MUL1: begin
                ideal_reg <= mul_p[DIV_DW-1:0];
                neg_reg   <= phase_diff[CPU_W];
            end
            ST_QRY_BASE: begin
                if (fine_reg) begin
                    subns_reg <= div_quo[SUBNS_W-1:0];
                end
            end
            ST_QRY_SUM: begin
                time_reg <= mul_p[TIME_W-1:0] + TIME_W'(subns_reg);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_time_reg  <= time_reg;
            m_fine_reg  <= fine_reg;
            m_done_reg  <= done_reg;
            m_mean_reg  <= mean_reg;
            m_drift_reg <= drift_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_time_ns          = m_time_reg;
    assign m_fine_used        = m_fine_reg;
    assign m_calibration_done = m_done_reg;
    assign m_mean_phase_out   = m_mean_reg;
    assign m_drift_out        = m_drift_reg;

    // A word taken in keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside the wait state");

    // The sample index never reaches the round length.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, idx_reg} < (IDX_W + 1)'(CAL_SAMPLES))
        else $error("sample index out of range");

    // No result is both an interpolated query and a round-closing sample.
    a_fine_xor_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_fine_used && m_calibration_done))
        else $error("result flags both query and calibration");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb
    import fti_pkg::*;
();

    localparam int CAL_ROUND    = 16;
    localparam int NS_IN_US     = 1000;
    localparam int PPM          = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int WATCHDOG     = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 140;
    localparam int REPORT_MAX   = 10;

    localparam logic [2:0] ADDR_CPU   = 3'd0;
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] cyc_first;
        logic [31:0] micro;
        logic [31:0] cyc_second;
    } stamp_word_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ns;
        logic               fine_used;
        logic               cal_done;
        logic [CPU_W-1:0]   avg_phase;
        logic [DRIFT_W-1:0] drift;
    } stamp_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [31:0] s_cycles_first = '0;
    logic [31:0] s_micro_count = '0;
    logic [31:0] s_cycles_second = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [TIME_W-1:0]         m_time_ns;
    logic                      m_fine_used;
    logic                      m_calibration_done;
    logic [CPU_W-1:0]          m_mean_phase_out;
    logic signed [DRIFT_W-1:0] m_drift_out;

    stamp_word_t   words_to_send[$];
    stamp_result_t expected_stamps[$];

    // Shadow of the interpolator's state and divisor setting.
    logic [CPU_W-1:0]   cpu_setting = CPU_RESET;
    logic [IDX_W-1:0]   cal_index = '0;
    logic [SUM_W-1:0]   phase_total = '0;
    logic [CPU_W-1:0]   round_first_phase = '0;
    logic [31:0]        round_first_us = '0;
    logic [CPU_W-1:0]   stored_mean = '0;
    logic [DRIFT_W-1:0] stored_drift = '0;
    logic               calibrated = 1'b0;

    // Timer model behind the well-formed random words.
    logic [31:0] gen_us = '0;
    logic [31:0] gen_offset = '0;

    logic src_idle_en = 1'b1;
    logic sink_idle_en = 1'b1;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   hold_left = 0;
    int   hold_requests = 0;
    int   hold_served = 0;

    int fail_cnt = 0;
    int result_cnt = 0;
    int sample_cnt = 0;
    int query_cnt = 0;
    int round_cnt = 0;
    int fine_cnt = 0;
    int setting_cnt = 1;
    int idle_run = 0;

    int          cpu_plan[8];
    logic [31:0] cpu_pick;

    fine_timestamp_interpolator_top #(
        .CAL_SAMPLES(CAL_ROUND)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_cycles_first(s_cycles_first),
        .s_micro_count(s_micro_count),
        .s_cycles_second(s_cycles_second),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_time_ns(m_time_ns),
        .m_fine_used(m_fine_used),
        .m_calibration_done(m_calibration_done),
        .m_mean_phase_out(m_mean_phase_out),
        .m_drift_out(m_drift_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    // Advances the shadow state by one word and returns the result it produces.
    function automatic stamp_result_t interpolate(stamp_word_t w);
        logic [31:0]   div;
        logic [31:0]   phase;
        logic [31:0]   mid;
        logic [31:0]   sub;
        logic [31:0]   sub_ns;
        longint        diff_l;
        longint        ideal_l;
        stamp_result_t r;

        div = (cpu_setting == '0) ? 32'd1 : {19'd0, cpu_setting};
        r = '0;
        if (w.action == ACT_SAMPLE) begin
            phase = w.cyc_first % div;
            if (cal_index == '0) begin
                phase_total = '0;
                round_first_phase = phase[CPU_W-1:0];
                round_first_us = w.micro;
            end
            phase_total = phase_total + phase[SUM_W-1:0];
            if (cal_index + 1 >= CAL_ROUND) begin
                stored_mean = CPU_W'(phase_total / CAL_ROUND);
                if (w.micro > round_first_us) begin
                    ideal_l = longint'(w.micro - round_first_us);
                    ideal_l = ideal_l * longint'(div);
                    diff_l = longint'(phase) - longint'(round_first_phase);
                    stored_drift = DRIFT_W'((diff_l * PPM) / ideal_l);
                end
                calibrated = 1'b1;
                r.cal_done = 1'b1;
                cal_index = '0;
            end else begin
                cal_index = cal_index + 1'b1;
            end
        end else begin
            r.time_ns = TIME_W'(w.micro) * TIME_W'(NS_IN_US);
            if (calibrated) begin
                mid = w.cyc_first + ((w.cyc_second - w.cyc_first) >> 1);
                sub = mid - stored_mean + div;
                sub = sub % div;
                sub_ns = (sub * NS_IN_US) / div;
                r.time_ns = r.time_ns + TIME_W'(sub_ns);
                r.fine_used = 1'b1;
            end
        end
        r.avg_phase = stored_mean;
        r.drift = stored_drift;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) $display("%s", msg);
    endtask

    task automatic push_word(input logic act, input logic [31:0] c1, input logic [31:0] us,
                             input logic [31:0] c2);
        stamp_word_t w;
        w.action = act;
        w.cyc_first = c1;
        w.micro = us;
        w.cyc_second = c2;
        words_to_send.push_back(w);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_CPU) cpu_setting = data[CPU_W-1:0];
    endtask

    // Checked on the falling edge so that everything done at the rising edge is settled.
    task automatic wait_idle();
        @(negedge aclk);
        while (words_to_send.size() != 0 || s_valid || expected_stamps.size() != 0)
            @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Mostly words from a steadily running timer with jittered edges, the rest noise.
    task automatic add_random_words(input int n);
        logic [31:0] eff;
        logic [31:0] c1;
        logic [31:0] c2;
        int          r;
        int          jit;

        eff = (cpu_setting == '0) ? 32'd1 : {19'd0, cpu_setting};
        gen_offset = $urandom_range(0, eff - 1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 19) == 0) gen_us = gen_us - $urandom_range(0, 200);
                else if ($urandom_range(0, 29) == 0) gen_us = $urandom;
                else gen_us = gen_us + $urandom_range(1, 40);
                if ($urandom_range(0, 19) == 0) gen_offset = $urandom_range(0, eff - 1);
                jit = $urandom_range(0, 8);
                c1 = gen_us * eff + gen_offset + jit - 4;
                push_word(ACT_SAMPLE, c1, gen_us, $urandom);
            end else if (r < 85) begin
                c1 = gen_us * eff + $urandom_range(0, 2 * eff);
                if ($urandom_range(0, 9) == 0) c2 = c1 - $urandom_range(1, 1000);
                else c2 = c1 + $urandom_range(0, 3 * eff);
                push_word(ACT_QUERY, c1, gen_us, c2);
            end else begin
                push_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
            end
        end
    endtask

    // Source side: one word at a time out of the pending queue.
    always @(posedge aclk) begin
        stamp_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (words_to_send.size() != 0) begin
                w = words_to_send.pop_front();
                s_valid <= 1'b1;
                s_action <= w.action;
                s_cycles_first <= w.cyc_first;
                s_micro_count <= w.micro;
                s_cycles_second <= w.cyc_second;
                src_gap <= src_idle_en ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls plus the occasional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end else if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            sink_gap <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Results are checked before the word accepted at the same edge is predicted.
    always @(posedge aclk) begin
        stamp_result_t got;
        stamp_result_t want;
        stamp_word_t   w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_time_ns, m_fine_used, m_calibration_done, m_mean_phase_out,
                       m_drift_out};
                result_cnt++;
                if (got.cal_done) round_cnt++;
                if (got.fine_used) fine_cnt++;
                if (expected_stamps.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing outstanding",
                                           result_cnt));
                end else begin
                    want = expected_stamps.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"result %0d mismatch: expected time %0d ",
                            "fine %0b done %0b phase %0d drift %0d, got time %0d fine %0b ",
                            "done %0b phase %0d drift %0d"}, result_cnt, want.time_ns,
                            want.fine_used, want.cal_done, want.avg_phase,
                            $signed(want.drift), got.time_ns, got.fine_used, got.cal_done,
                            got.avg_phase, $signed(got.drift)));
                end
            end
            if (s_valid && s_ready) begin
                w.action = s_action;
                w.cyc_first = s_cycles_first;
                w.micro = s_micro_count;
                w.cyc_second = s_cycles_second;
                if (s_action == ACT_SAMPLE) sample_cnt++;
                else query_cnt++;
                expected_stamps.push_back(interpolate(w));
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_run = 0;
            else idle_run++;
            if (idle_run >= WATCHDOG) begin
                $display("no word moved for %0d cycles", WATCHDOG);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        cpu_plan[0] = 1;
        cpu_plan[1] = 4294;
        cpu_plan[2] = 0;
        cpu_plan[3] = 8191;
        cpu_plan[4] = $urandom_range(2, 4294);
        cpu_plan[5] = 200;
        cpu_plan[6] = 13;
        cpu_plan[7] = $urandom_range(1, 8191);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset divisor: uncalibrated queries, one full round
        // ending in a large positive drift, then calibrated queries with wrapping
        // counts, and a few samples that leave the round open across a divisor change.
        push_word(ACT_QUERY, 32'd0, 32'd0, 32'd0);
        push_word(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        push_word(ACT_SAMPLE, 32'd0, 32'd100, 32'hFFFF_FFFF);
        push_word(ACT_SAMPLE, 32'hFFFF_FFFF, 32'd0, 32'd0);
        for (int i = 2; i < CAL_ROUND - 1; i++)
            push_word(ACT_SAMPLE, $urandom, $urandom, $urandom);
        push_word(ACT_SAMPLE, 32'd200 * 32'd7000 + 32'd150, 32'd101, 32'd0);
        push_word(ACT_QUERY, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd16);
        push_word(ACT_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF);
        push_word(ACT_QUERY, 32'd3, 32'd12345, 32'd3);
        for (int i = 0; i < 3; i++)
            push_word(ACT_SAMPLE, $urandom, $urandom_range(0, 1000), $urandom);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            cpu_pick = cpu_plan[p];
            apb_write(ADDR_CPU, cpu_pick);
            // A write to an unmapped address must leave the divisor alone.
            if (p == 4) apb_write(ADDR_SPARE, $urandom);
            setting_cnt++;
            src_idle_en <= (p != 1 && p != 5);
            sink_idle_en <= (p != 1 && p != 6);
            add_random_words(RANDOM_WORDS);
            if (p == 3 || p == 6) hold_requests <= hold_requests + 1;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_stamps.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_stamps.size()));

        $display("Ran %0d sample words and %0d query words over %0d divisor settings.",
                 sample_cnt, query_cnt, setting_cnt);
        $display("%0d calibration rounds closed, %0d queries interpolated, %0d failures.",
                 round_cnt, fine_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
